>>> hw/rtl/qsu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the quartile summary block.
// No dependencies; every other file imports this package.
package qsu_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 42;
    localparam int FRAC_W      = 8;
    localparam int MEAN_W      = 40;
    localparam int OUT_CNT_W   = 11;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DIV_W       = SUM_W + FRAC_W;
    localparam int STEP_W      = $clog2(DIV_W + 1);

    typedef struct packed {
        logic [DATA_W-1:0] sample_value;
        logic              carries_sample;
        logic              last_sample;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0]    min_value;
        logic [DATA_W-1:0]    low_quartile;
        logic [DATA_W-1:0]    median_value;
        logic [DATA_W-1:0]    high_quartile;
        logic [DATA_W-1:0]    max_value;
        logic [SUM_W-1:0]     sum_total;
        logic [MEAN_W-1:0]    mean_fixed;
        logic [OUT_CNT_W-1:0] sample_count;
        logic                 overflow_flag;
    } t_out_word;

    // Per-cycle command broadcast along the cell chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_FILL  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

endpackage

>>> hw/rtl/qsu_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a single sample.
// Depends on qsu_pkg.
module qsu_cell (
    input  logic                    i_clk,
    input  qsu_pkg::t_cell_ctl      i_ctl,
    input  logic                    i_occ,
    input  logic [qsu_pkg::DATA_W-1:0] i_new,
    input  logic [qsu_pkg::DATA_W-1:0] i_left_val,
    input  logic                    i_left_lt,
    input  logic [qsu_pkg::DATA_W-1:0] i_right_val,
    output logic [qsu_pkg::DATA_W-1:0] o_val,
    output logic                    o_lt
);
    import qsu_pkg::*;

    logic [DATA_W-1:0] r_val;

    // An empty cell counts as larger than any sample.
    assign o_lt  = !i_occ || (i_new < r_val);
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_val <= i_right_val;
        end else if (i_ctl.insert && o_lt) begin
            // shift right to make room, or take the new sample at the gap
            r_val <= i_left_lt ? i_left_val : i_new;
        end
    end

endmodule

>>> hw/rtl/qsu_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for the mean: one quotient bit per cycle.
// Depends on qsu_pkg.
module qsu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qsu_pkg::DIV_W-1:0]   i_dividend,
    input  logic [qsu_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [qsu_pkg::MEAN_W-1:0]  o_quot
);
    import qsu_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_q;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_d;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem[CNT_W-1:0], r_q[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign o_busy  = r_busy;
    assign o_quot  = r_q[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIV_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff : w_trial;
        end
    end

endmodule

>>> hw/rtl/quartile_summary_unsigned.sv
`timescale 1ns / 1ps
// Quartile summary top level: sorted cell chain, drain control, mean divider.
// Depends on qsu_pkg, qsu_cell and qsu_div.
//
// Input channel (i_valid / o_stall / i_data): one sample word per cycle while o_stall is low.
// Each sample is inserted into a chain of MAX_SAMPLES cells that keeps the
// set in ascending order; a word with last_sample closes the set.
// Output channel (o_valid / i_stall / o_data): one summary word per set.
// Flow: an ordinary sample is inserted as it is taken and is never stalled
// while the block fills. A closing word of a set of N samples starts a
// drain of the chain, run beside a serial divider for the mean; the
// summary is registered once both the drain and the divider are done.
// An empty set reports on the next cycle. During the drain o_stall is
// high. Once a summary is held, new samples are taken again; only a
// further closing word waits until the held summary has gone. The
// receiver may stall as long as it likes: the word holds steady in its
// register.
// Reset (synchronous, active low) empties the set and drops any held
// summary; the cell contents are left as they are and are unused.
// Samples beyond capacity are dropped and reported by overflow_flag.
module quartile_summary_unsigned (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qsu_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output qsu_pkg::t_out_word o_data
);
    import qsu_pkg::*;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_flag;
    logic              r_res_valid;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_k;
    logic              r_drain_done;
    logic [CNT_W-1:0]  r_idx_lo;
    logic [CNT_W-1:0]  r_idx_med;
    logic [CNT_W-1:0]  r_idx_hi;
    t_out_word         r_res;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_full;
    logic              w_ins;
    logic              w_drop;
    logic              w_close;
    logic [CNT_W-1:0]  w_cnt_new;
    logic [SUM_W-1:0]  w_sum_new;
    logic              w_flag_new;
    logic [CNT_W+1:0]  w_n3;
    logic              w_div_busy;
    logic [MEAN_W-1:0] w_quot;
    t_cell_ctl         w_ctl;

    logic [DATA_W-1:0] w_val [MAX_SAMPLES];
    logic              w_lt  [MAX_SAMPLES];
    logic              w_occ [MAX_SAMPLES];

    // Handshakes: hold off all input during the drain, and a closing word while a summary still waits.
    assign o_stall   = (r_state != S_FILL) || (r_res_valid && i_data.last_sample);
    assign w_in_acc  = i_valid && !o_stall;
    assign o_valid   = r_res_valid;
    assign o_data    = r_res;
    assign w_out_acc = r_res_valid && !i_stall;

    // Set bookkeeping: drop a sample once every cell is taken.
    assign w_full     = (r_count == CNT_W'(MAX_SAMPLES));
    assign w_ins      = w_in_acc && i_data.carries_sample && !w_full;
    assign w_drop     = w_in_acc && i_data.carries_sample && w_full;
    assign w_close    = w_in_acc && i_data.last_sample;
    assign w_cnt_new  = w_ins ? r_count + 1'b1 : r_count;
    assign w_sum_new  = w_ins ? r_sum + SUM_W'(i_data.sample_value) : r_sum;
    assign w_flag_new = r_flag || w_drop;
    assign w_n3       = {2'b00, w_cnt_new} + {1'b0, w_cnt_new, 1'b0};

    assign w_ctl.insert = w_ins;
    assign w_ctl.drain  = (r_state == S_DRAIN);

    // Sorted chain: cell 0 holds the smallest sample; the drain shifts
    // every cell one place towards cell 0 per cycle.
    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic [DATA_W-1:0] w_left_val;
        logic              w_left_lt;
        logic [DATA_W-1:0] w_right_val;

        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_lt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_tail
            assign w_right_val = '0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        qsu_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[g]),
            .i_new       (i_data.sample_value),
            .i_left_val  (w_left_val),
            .i_left_lt   (w_left_lt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_lt        (w_lt[g])
        );
    end

    // Mean = (total << 8) / count, started as the set closes.
    qsu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_close && (w_cnt_new != '0)),
        .i_dividend ({w_sum_new, {FRAC_W{1'b0}}}),
        .i_divisor  (w_cnt_new),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_count      <= '0;
            r_sum        <= '0;
            r_flag       <= 1'b0;
            r_res_valid  <= 1'b0;
            r_n          <= '0;
            r_k          <= '0;
            r_drain_done <= 1'b0;
        end else begin
            if (w_out_acc) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_FILL: begin
                    if (w_close) begin
                        // clear the set; an empty set reports at once
                        r_count      <= '0;
                        r_sum        <= '0;
                        r_flag       <= 1'b0;
                        r_n          <= w_cnt_new;
                        r_k          <= '0;
                        r_drain_done <= 1'b0;
                        if (w_cnt_new == '0) begin
                            r_res_valid <= 1'b1;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_count <= w_cnt_new;
                        r_sum   <= w_sum_new;
                        r_flag  <= w_flag_new;
                    end
                end
                S_DRAIN: begin
                    if (!r_drain_done) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == r_n - 1'b1) begin
                            r_drain_done <= 1'b1;
                        end
                    end else if (!w_div_busy) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_FILL;
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // Summary word and quartile positions.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL && w_close) begin
            r_idx_lo  <= w_cnt_new >> 2;
            r_idx_med <= w_cnt_new >> 1;
            r_idx_hi  <= w_n3[CNT_W+1:2];
            // an empty set has a zero count and a zero total
            r_res.min_value     <= '0;
            r_res.low_quartile  <= '0;
            r_res.median_value  <= '0;
            r_res.high_quartile <= '0;
            r_res.max_value     <= '0;
            r_res.sum_total     <= w_sum_new;
            r_res.mean_fixed    <= '0;
            r_res.sample_count  <= OUT_CNT_W'(w_cnt_new);
            r_res.overflow_flag <= w_flag_new;
        end else if (r_state == S_DRAIN) begin
            if (!r_drain_done) begin
                // cell 0 holds sorted element r_k in this cycle
                if (r_k == '0) begin
                    r_res.min_value <= w_val[0];
                end
                if (r_k == r_idx_lo) begin
                    r_res.low_quartile <= w_val[0];
                end
                if (r_k == r_idx_med) begin
                    r_res.median_value <= w_val[0];
                end
                if (r_k == r_idx_hi) begin
                    r_res.high_quartile <= w_val[0];
                end
                if (r_k == r_n - 1'b1) begin
                    r_res.max_value <= w_val[0];
                end
            end else if (!w_div_busy) begin
                r_res.mean_fixed <= w_quot;
            end
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above capacity");

    a_drain_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> o_stall)
        else $error("input taken during drain");

    a_fill_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !w_div_busy)
        else $error("divider still busy after drain");

    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) == S_DRAIN) || $past(w_close))
        else $error("summary raised without a closed set");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !r_drain_done) |-> (r_k < r_n))
        else $error("drain ran past the set");

endmodule

>>> sim/quartile_summary_unsigned_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quartile_summary_unsigned: streams sample sets under
// random sender gaps and receiver stalls and checks every summary word in order.
// Depends on qsu_pkg and the quartile_summary_unsigned RTL; reads nothing else.
module quartile_summary_unsigned_tb;
    import qsu_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 200;

    // Value flavours for one set of samples
    localparam int VAL_WIDE    = 0;
    localparam int VAL_NARROW  = 1;
    localparam int VAL_EXTREME = 2;
    localparam int VAL_TOP     = 3;

    // Keeps the set as it should stand inside the block, and the queue of
    // summary words the block owes us.
    class summary_board;
        bit [DATA_W-1:0] sorted_set[$];
        bit [SUM_W-1:0]  set_sum;
        bit              set_dropped;
        t_out_word       summary_q[$];
        int              errors;
        int              summaries;
        int              overflow_sets;

        // Fold an accepted input word into the set; queue a summary on close.
        function void note_word(t_in_word w);
            int        pos;
            int        n;
            bit [63:0] scaled;
            t_out_word want;
            if (w.carries_sample) begin
                if (sorted_set.size() >= MAX_SAMPLES) begin
                    set_dropped = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < sorted_set.size() && sorted_set[pos] <= w.sample_value)
                        pos++;
                    sorted_set.insert(pos, w.sample_value);
                    set_sum = set_sum + w.sample_value;
                end
            end
            if (w.last_sample) begin
                want = '0;
                n = sorted_set.size();
                if (n > 0) begin
                    want.min_value     = sorted_set[0];
                    want.low_quartile  = sorted_set[n / 4];
                    want.median_value  = sorted_set[n / 2];
                    want.high_quartile = sorted_set[(3 * n) / 4];
                    want.max_value     = sorted_set[n - 1];
                    want.sum_total     = set_sum;
                    scaled = {{(64 - SUM_W){1'b0}}, set_sum} << FRAC_W;
                    scaled = scaled / 64'(n);
                    want.mean_fixed    = scaled[MEAN_W-1:0];
                    want.sample_count  = n[OUT_CNT_W-1:0];
                end
                want.overflow_flag = set_dropped;
                if (set_dropped)
                    overflow_sets++;
                summary_q.push_back(want);
                sorted_set.delete();
                set_sum     = '0;
                set_dropped = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Match one accepted summary word against the oldest one owed.
        function void check_word(t_out_word got);
            t_out_word want;
            if (summary_q.size() == 0) begin
                errors++;
                $display("%0t ns: summary word with none pending, expected none, actual %h",
                         $time, got);
                return;
            end
            want = summary_q.pop_front();
            summaries++;
            compare_field("min_value",     want.min_value,     got.min_value);
            compare_field("low_quartile",  want.low_quartile,  got.low_quartile);
            compare_field("median_value",  want.median_value,  got.median_value);
            compare_field("high_quartile", want.high_quartile, got.high_quartile);
            compare_field("max_value",     want.max_value,     got.max_value);
            compare_field("sum_total",     want.sum_total,     got.sum_total);
            compare_field("mean_fixed",    want.mean_fixed,    got.mean_fixed);
            compare_field("sample_count",  want.sample_count,  got.sample_count);
            compare_field("overflow_flag", want.overflow_flag, got.overflow_flag);
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_word   i_data  = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_word  o_data;

    summary_board sb;
    int           idle_pct    = 37;
    int           stall_pct   = 66;
    int           items_sent  = 0;
    int           cycle_count = 0;

    quartile_summary_unsigned dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost summary ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d summaries still pending",
                     $time, sb.summary_q.size());
            $display("quartile_summary_unsigned verification failed");
            $finish;
        end
    end

    // Receiver: take a summary word when valid meets no stall, then pick the
    // stall for the next cycle independently of anything the block shows.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_data);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one word, with random gaps ahead of it, and hold it until taken.
    // Called at a rising edge; returns at the edge that accepted the word.
    task automatic send_word(bit [DATA_W-1:0] value, bit has, bit last);
        t_in_word w;
        w.sample_value   = value;
        w.carries_sample = has;
        w.last_sample    = last;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_word(w);
        // Words with neither flag are ignored by the block; do not count them.
        if (has || last)
            items_sent++;
    endtask

    function automatic bit [DATA_W-1:0] pick_value(int flavour);
        case (flavour)
            VAL_WIDE:   return $urandom();
            VAL_NARROW: return $urandom_range(15);
            VAL_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default:    return 32'hFFFF_FFFF - $urandom_range(255);
        endcase
    endfunction

    // One set of n samples, sprinkled with ignored words, then the closing word.
    task automatic send_set(int n, bit close_with_sample);
        int flavour;
        flavour = $urandom_range(VAL_TOP);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                send_word($urandom(), 1'b0, 1'b0);
            send_word(pick_value(flavour), 1'b1, 1'b0);
        end
        send_word(pick_value(flavour), close_with_sample, 1'b1);
    endtask

    // Random sets until the phase has moved its share of words; small sets
    // dominate so the drain and divider see many closings.
    task automatic run_phase(int idle, int stall, int budget);
        int stop_at;
        int n;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = items_sent + budget;
        while (items_sent < stop_at) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
            send_set(n, $urandom_range(1));
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Empty set: every field zero.
        send_word(32'h1234_5678, 1'b0, 1'b1);
        // An ignored word, then a single zero sample on the closing word.
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b1);
        // Single all-ones sample carried by the closing word.
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        // Three extremes and a one, out of order, closed without a sample.
        send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'h8000_0000, 1'b1, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        // Equal samples throughout.
        send_word(32'h0000_0007, 1'b1, 1'b0);
        send_word(32'h0000_0007, 1'b1, 1'b0);
        send_word(32'h0000_0007, 1'b1, 1'b0);
        send_word(32'h0000_0007, 1'b1, 1'b1);
        // Descending run: every insert lands at the bottom of the chain.
        send_word(32'h0000_0005, 1'b1, 1'b0);
        send_word(32'h0000_0004, 1'b1, 1'b0);
        send_word(32'h0000_0003, 1'b1, 1'b0);
        send_word(32'h0000_0002, 1'b1, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b1);

        // Random part: sender idles lightly and receiver heavily, then swap.
        run_phase(37, 66, PHASE_ITEMS);
        run_phase(66, 37, PHASE_ITEMS);

        // No idling from here. Fill the store to capacity and push on: the
        // three extra samples and the closing sample are dropped and flagged.
        idle_pct  = 0;
        stall_pct = 0;
        for (int k = 0; k < MAX_SAMPLES + 3; k++)
            send_word(($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom(), 1'b1, 1'b0);
        send_word($urandom(), 1'b1, 1'b1);
        run_phase(0, 0, PHASE_ITEMS);
        i_valid <= 1'b0;

        // Drain: wait for every owed summary, then let a stray one show up.
        while (sb.summary_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words in %0d summaries, %0d of them with dropped samples,",
                 items_sent, sb.summaries, sb.overflow_sets);
        $display("under three idling mixes on sender and receiver, with %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("quartile_summary_unsigned verification clean");
        end else begin
            $display("quartile_summary_unsigned verification failed");
        end
        $finish;
    end

endmodule
